[design/knn_pkg.sv]
// Shared types and constants for the k-nearest-neighbor row update block.
`timescale 1ns / 1ps
`default_nettype none

package knn_pkg;

  localparam int unsigned ROW_IN_W     = 10;
  localparam int unsigned ID_W         = 10;
  localparam int unsigned SIM_IN_W     = 16;
  localparam int unsigned SLOT_OUT_W   = 4;
  localparam int unsigned FILL_OUT_W   = 5;
  localparam int unsigned KEEP_W       = 5;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

  localparam int unsigned NUM_ROWS_DEF      = 1024;
  localparam int unsigned MAX_NEIGHBORS_DEF = 16;
  localparam int unsigned SIM_BITS_DEF      = 16;
  localparam int unsigned QUEUE_DEPTH       = 2;

  typedef enum logic [1:0] {
    OUTC_APPENDED  = 2'd0,
    OUTC_DUPLICATE = 2'd1,
    OUTC_REPLACED  = 2'd2,
    OUTC_REJECTED  = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [ROW_IN_W-1:0]      row_index;
    logic [ID_W-1:0]          neighbor_id;
    logic signed [SIM_IN_W-1:0] similarity;
  } in_beat_t;

  typedef struct packed {
    outcome_t                outcome;
    logic [SLOT_OUT_W-1:0]   slot;
    logic [FILL_OUT_W-1:0]   fill_after;
  } out_beat_t;

endpackage

`default_nettype wire

[design/knn_front.sv]
// Front end: input register, similarity saturation and row folding into the table range.
`timescale 1ns / 1ps
`default_nettype none

module knn_front import knn_pkg::*; #(
  parameter int unsigned ROWS_USED = NUM_ROWS_DEF,
  parameter int unsigned ROW_AW    = 10,
  parameter int unsigned SIM_BITS  = SIM_BITS_DEF,
  parameter int unsigned ITEM_W    = ROW_AW + ID_W + SIM_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_beat_t          in_data,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output logic [ITEM_W-1:0]      push_data
);

  localparam int unsigned SHIFT     = ROW_IN_W + ROW_AW;
  localparam int unsigned RECIP_W   = ROW_IN_W + 2;
  localparam int unsigned RECIP_VAL = ((1 << SHIFT) + ROWS_USED - 1) / ROWS_USED;
  localparam int unsigned PROD_W    = ROW_IN_W + RECIP_W;
  localparam int unsigned QN_W      = ROW_IN_W + ROW_AW + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
  localparam logic [ROW_AW:0]    NROWS = (ROW_AW + 1)'(ROWS_USED);

  logic signed [SIM_BITS-1:0] sim_sat;

  logic                       s1_v_r, s1_v_nxt;
  logic [ROW_IN_W-1:0]        s1_row_r;
  logic [ID_W-1:0]            s1_id_r;
  logic signed [SIM_BITS-1:0] s1_sim_r;

  logic                       s2_v_r, s2_v_nxt;
  logic [ROW_IN_W-1:0]        s2_row_r;
  logic [ROW_IN_W-1:0]        s2_q_r;
  logic [ID_W-1:0]            s2_id_r;
  logic signed [SIM_BITS-1:0] s2_sim_r;

  logic                       take, s1_adv, s2_adv;
  logic [PROD_W-1:0]          prod;
  logic [ROW_IN_W-1:0]        quot;
  logic [QN_W-1:0]            qn;
  logic [ROW_IN_W-1:0]        rem_full;

  if (SIM_BITS >= SIM_IN_W) begin : g_ext
    assign sim_sat = SIM_BITS'(in_data.similarity);
  end else begin : g_sat
    localparam logic signed [SIM_IN_W-1:0] SAT_HI = SIM_IN_W'((1 << (SIM_BITS - 1)) - 1);
    localparam logic signed [SIM_IN_W-1:0] SAT_LO = -SAT_HI - SIM_IN_W'(1);
    logic signed [SIM_IN_W-1:0] clamped;
    always_comb begin
      if (in_data.similarity > SAT_HI) begin
        clamped = SAT_HI;
      end else if (in_data.similarity < SAT_LO) begin
        clamped = SAT_LO;
      end else begin
        clamped = in_data.similarity;
      end
    end
    assign sim_sat = clamped[SIM_BITS-1:0];
  end

  assign s2_adv   = s2_v_r && push_ready;
  assign s1_adv   = s1_v_r && (!s2_v_r || s2_adv);
  assign in_ready = !s1_v_r || s1_adv;
  assign take     = in_valid && in_ready;

  // Row modulo the table size: exact reciprocal multiply, then a back-multiply.
  assign prod     = PROD_W'(s1_row_r) * PROD_W'(RECIP);
  assign quot     = ROW_IN_W'(prod >> SHIFT);
  assign qn       = QN_W'(s2_q_r) * QN_W'(NROWS);
  assign rem_full = s2_row_r - ROW_IN_W'(qn);

  assign push_valid = s2_v_r;
  assign push_data  = {rem_full[ROW_AW-1:0], s2_id_r, s2_sim_r};

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (take) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (s1_adv) begin
      s2_v_nxt = 1'b1;
    end else if (s2_adv) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_row_r <= in_data.row_index;
      s1_id_r  <= in_data.neighbor_id;
      s1_sim_r <= sim_sat;
    end
    if (s1_adv) begin
      s2_row_r <= s1_row_r;
      s2_q_r   <= quot;
      s2_id_r  <= s1_id_r;
      s2_sim_r <= s1_sim_r;
    end
  end

endmodule

`default_nettype wire

[design/knn_queue.sv]
// Small FIFO that decouples the front end from the row update engine.
`timescale 1ns / 1ps
`default_nettype none

module knn_queue import knn_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = count_r != CNT_FULL;
  assign rd_valid = count_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[design/knn_back.sv]
// Row update engine: fill and neighbor memories, minimum search tree and result register.
`timescale 1ns / 1ps
`default_nettype none

module knn_back import knn_pkg::*; #(
  parameter int unsigned ROWS_USED     = NUM_ROWS_DEF,
  parameter int unsigned ROW_AW        = 10,
  parameter int unsigned MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
  parameter int unsigned SIM_BITS      = SIM_BITS_DEF,
  parameter int unsigned CNT_W         = $clog2(MAX_NEIGHBORS + 1),
  parameter int unsigned ITEM_W        = ROW_AW + ID_W + SIM_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CNT_W-1:0]  k_eff,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire logic [ITEM_W-1:0] q_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_beat_t              out_data,
  output logic                   clearing
);

  localparam int unsigned SLOT_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned LEAVES  = 1 << $clog2(MAX_NEIGHBORS);
  localparam int unsigned SLOT_XW = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;
  localparam int unsigned FILL_XW = (CNT_W > FILL_OUT_W) ? CNT_W : FILL_OUT_W;
  localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS_USED - 1);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOK   = 4'b0100,
    ST_DECIDE = 4'b1000
  } back_state_t;

  back_state_t                state_r, state_nxt;
  logic [ROW_AW-1:0]          clr_addr_r, clr_addr_nxt;

  logic [ROW_AW-1:0]          q_row;
  logic [ID_W-1:0]            q_id;
  logic signed [SIM_BITS-1:0] q_sim;

  logic [ROW_AW-1:0]          cur_row_r;
  logic [ID_W-1:0]            cur_id_r;
  logic signed [SIM_BITS-1:0] cur_sim_r;

  logic [CNT_W-1:0]           fill_mem [ROWS_USED];
  logic [CNT_W-1:0]           fill_rd_r;
  wire  [MAX_NEIGHBORS-1:0][ID_W-1:0]     id_rd;
  wire  [MAX_NEIGHBORS-1:0][SIM_BITS-1:0] sim_rd;

  logic                       dup_r, full_r;
  logic [CNT_W-1:0]           cnt_r;
  logic signed [SIM_BITS-1:0] min_val_r;
  logic [SLOT_W-1:0]          min_slot_r;

  logic                       out_valid_r, out_valid_nxt;
  out_beat_t                  out_data_r;

  logic                       pop, done, out_free;
  logic [CNT_W-1:0]           lim;
  logic                       dup_c;
  logic                       node_v   [2*LEAVES];
  logic signed [SIM_BITS-1:0] node_val [2*LEAVES];
  logic [SLOT_W-1:0]          node_idx [2*LEAVES];
  logic                       take_b;

  outcome_t                   dec_outcome;
  logic [SLOT_W-1:0]          dec_slot;
  logic [CNT_W-1:0]           dec_fill;
  logic                       lane_we, fill_we;
  logic                       fill_wr_en;
  logic [ROW_AW-1:0]          fill_wr_addr;
  logic [CNT_W-1:0]           fill_wr_data;
  logic [SLOT_XW-1:0]         slot_x;
  logic [FILL_XW-1:0]         fill_x;

  assign q_row = q_data[ITEM_W-1 -: ROW_AW];
  assign q_id  = q_data[SIM_BITS +: ID_W];
  assign q_sim = q_data[SIM_BITS-1:0];

  assign clearing = state_r == ST_CLEAR;
  assign out_free = !out_valid_r || out_ready;
  assign done     = (state_r == ST_DECIDE) && out_free;
  assign pop      = q_valid && ((state_r == ST_IDLE) ||
                                (done && q_row != cur_row_r));
  assign q_ready  = pop;

  // Parallel duplicate check and first-minimum tree over the row just read.
  always_comb begin
    lim   = (fill_rd_r < k_eff) ? fill_rd_r : k_eff;
    dup_c = 1'b0;
    for (int s = 0; s < MAX_NEIGHBORS; s++) begin
      if ((CNT_W'(s) < lim) && (id_rd[s] == cur_id_r)) begin
        dup_c = 1'b1;
      end
    end
    node_v[0]   = 1'b0;
    node_val[0] = '0;
    node_idx[0] = '0;
    for (int s = 0; s < LEAVES; s++) begin
      if (s < MAX_NEIGHBORS) begin
        node_v[LEAVES+s]   = CNT_W'(s) < k_eff;
        node_val[LEAVES+s] = $signed(sim_rd[s]);
      end else begin
        node_v[LEAVES+s]   = 1'b0;
        node_val[LEAVES+s] = '0;
      end
      node_idx[LEAVES+s] = SLOT_W'(s);
    end
    for (int i = LEAVES - 1; i >= 1; i--) begin
      take_b = node_v[2*i+1] &&
               (!node_v[2*i] || (node_val[2*i+1] < node_val[2*i]));
      node_v[i]   = node_v[2*i] || node_v[2*i+1];
      node_val[i] = take_b ? node_val[2*i+1] : node_val[2*i];
      node_idx[i] = take_b ? node_idx[2*i+1] : node_idx[2*i];
    end
  end

  always_comb begin
    dec_outcome = OUTC_DUPLICATE;
    dec_slot    = '0;
    dec_fill    = cnt_r;
    if (dup_r) begin
      dec_outcome = OUTC_DUPLICATE;
    end else if (!full_r) begin
      dec_outcome = OUTC_APPENDED;
      dec_slot    = cnt_r[SLOT_W-1:0];
      dec_fill    = cnt_r + CNT_W'(1);
    end else if (cur_sim_r > min_val_r) begin
      dec_outcome = OUTC_REPLACED;
      dec_slot    = min_slot_r;
    end else begin
      dec_outcome = OUTC_REJECTED;
      dec_slot    = min_slot_r;
    end
    lane_we = done && (dec_outcome == OUTC_APPENDED || dec_outcome == OUTC_REPLACED);
    fill_we = done && (dec_outcome == OUTC_APPENDED);
    slot_x  = SLOT_XW'(dec_slot);
    fill_x  = FILL_XW'(dec_fill);
  end

  always_comb begin
    fill_wr_en   = fill_we;
    fill_wr_addr = cur_row_r;
    fill_wr_data = dec_fill;
    if (state_r == ST_CLEAR) begin
      fill_wr_en   = 1'b1;
      fill_wr_addr = clr_addr_r;
      fill_wr_data = '0;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ROW_AW'(1);
        if (clr_addr_r == ROW_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (done) begin
          state_nxt = pop ? ST_LOOK : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_row_r <= q_row;
      cur_id_r  <= q_id;
      cur_sim_r <= q_sim;
      fill_rd_r <= fill_mem[q_row];
    end
    if (fill_wr_en) begin
      fill_mem[fill_wr_addr] <= fill_wr_data;
    end
    if (state_r == ST_LOOK) begin
      dup_r      <= dup_c;
      full_r     <= fill_rd_r >= k_eff;
      cnt_r      <= fill_rd_r;
      min_val_r  <= node_val[1];
      min_slot_r <= node_idx[1];
    end
    if (done) begin
      out_data_r.outcome    <= dec_outcome;
      out_data_r.slot       <= slot_x[SLOT_OUT_W-1:0];
      out_data_r.fill_after <= fill_x[FILL_OUT_W-1:0];
    end
  end

  for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_lane
    logic [ID_W-1:0]     id_mem  [ROWS_USED];
    logic [SIM_BITS-1:0] sim_mem [ROWS_USED];
    logic [ID_W-1:0]     id_q_r;
    logic [SIM_BITS-1:0] sim_q_r;

    always_ff @(posedge clk) begin
      if (lane_we && (dec_slot == SLOT_W'(g))) begin
        id_mem[cur_row_r]  <= cur_id_r;
        sim_mem[cur_row_r] <= cur_sim_r;
      end
      if (pop) begin
        id_q_r  <= id_mem[q_row];
        sim_q_r <= sim_mem[q_row];
      end
    end

    assign id_rd[g]  = id_q_r;
    assign sim_rd[g] = sim_q_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[design/knn_top_k_neighbor_update.sv]
// Top level of the k-nearest-neighbor row update block: configuration, front end, queue, engine.
// Path: front-end input and fold registers, queue, engine read, search and decide steps, result
// register, plus queue and output waits. A new item is taken only as the last one finishes
// the row memories' read, search and write-back loop; a same-row item also waits for an idle step.
// Reset: synchronous; afterwards the fill counts are cleared one row per cycle, min(NUM_ROWS, 1024)
// rows in all, during which in_ready stays low. The keep count (keep_r) resets to 16.
`timescale 1ns / 1ps
`default_nettype none

module knn_top_k_neighbor_update import knn_pkg::*; #(
  parameter int unsigned NUM_ROWS      = NUM_ROWS_DEF,
  parameter int unsigned MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
  parameter int unsigned SIM_BITS      = SIM_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [KEEP_W-1:0] cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_beat_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_beat_t              out_data
);

  localparam int unsigned ROW_SPAN  = 1 << ROW_IN_W;
  localparam int unsigned ROWS_USED = (NUM_ROWS < ROW_SPAN) ? NUM_ROWS : ROW_SPAN;
  localparam int unsigned ROW_AW    = $clog2(ROWS_USED);
  localparam int unsigned CNT_W     = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned ITEM_W    = ROW_AW + ID_W + SIM_BITS;
  localparam int unsigned KX_W      = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

  logic [KEEP_W-1:0] keep_r;
  logic [KX_W-1:0]   keep_x, k_x;
  logic [CNT_W-1:0]  k_eff;
  logic              clearing;
  logic              fr_valid, fr_ready;
  logic              push_valid, push_ready;
  logic [ITEM_W-1:0] push_data;
  logic              q_valid, q_ready;
  logic [ITEM_W-1:0] q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= KEEP_RESET;
    end else if (cfg_wr_en) begin
      keep_r <= cfg_wr_data;
    end
  end

  // A zero count acts as one, and counts above MAX_NEIGHBORS are clamped to it.
  always_comb begin
    keep_x = KX_W'(keep_r);
    if (keep_r == '0) begin
      k_x = KX_W'(1);
    end else if (keep_x > KX_W'(MAX_NEIGHBORS)) begin
      k_x = KX_W'(MAX_NEIGHBORS);
    end else begin
      k_x = keep_x;
    end
  end
  assign k_eff = k_x[CNT_W-1:0];

  assign fr_valid = in_valid && !clearing;
  assign in_ready = fr_ready && !clearing;

  knn_front #(
    .ROWS_USED (ROWS_USED),
    .ROW_AW    (ROW_AW),
    .SIM_BITS  (SIM_BITS),
    .ITEM_W    (ITEM_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (fr_valid),
    .in_ready   (fr_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  knn_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  knn_back #(
    .ROWS_USED     (ROWS_USED),
    .ROW_AW        (ROW_AW),
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .SIM_BITS      (SIM_BITS),
    .CNT_W         (CNT_W),
    .ITEM_W        (ITEM_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .k_eff     (k_eff),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .clearing  (clearing)
  );

  // An append always lands in the slot just below the new fill count.
  a_append_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.outcome == OUTC_APPENDED) |->
      ((MAX_NEIGHBORS > 16) ||
       (out_data.fill_after == FILL_OUT_W'(out_data.slot) + FILL_OUT_W'(1))))
    else $error("append result slot does not match fill count");

  // Replacement and rejection only happen on a full row.
  a_full_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.outcome == OUTC_REPLACED ||
                   out_data.outcome == OUTC_REJECTED)) |->
      ((MAX_NEIGHBORS > 16) || (out_data.fill_after >= FILL_OUT_W'(k_eff))))
    else $error("replacement decision on a row that is not full");

  // A duplicate never reports a slot.
  a_dup_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.outcome == OUTC_DUPLICATE) |-> (out_data.slot == '0))
    else $error("duplicate result carries a slot");

  // No result beat can be pending while the fill counts are being cleared.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (!out_valid && !q_valid))
    else $error("activity during the fill count clearing pass");

endmodule

`default_nettype wire
